// File: hw/rtl/mesh_normal_accumulator_defines.svh
// assertion macros used by the mesh normal accumulator controller
`ifndef MESH_NORMAL_ACCUMULATOR_DEFINES_SVH
`define MESH_NORMAL_ACCUMULATOR_DEFINES_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define MNA_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mna check failed");

// antecedent holds in this cycle, consequent in the next cycle
`define MNA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mna check failed");

`endif

// File: hw/rtl/mna_pkg.sv
// types, codes and constants of the mesh normal accumulator
package mna_pkg;

    localparam int MAX_VERTICES_DEF  = 1024;
    localparam int MAX_TRIANGLES_DEF = 2048;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 64;
    localparam logic [11:0] COUNT_MAX = 12'd4095;

    // item modes
    localparam logic [1:0] MODE_VTX_WR = 2'd0;
    localparam logic [1:0] MODE_TRI    = 2'd1;
    localparam logic [1:0] MODE_VNORM  = 2'd2;
    localparam logic [1:0] MODE_FNORM  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SLOT   = 2'd1;
    localparam logic [1:0] ST_CORNER = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    // datapath index selects
    localparam logic [3:0] ASEL_SLOT   = 4'd3;
    localparam logic [3:0] MUL_SQ_BASE = 4'd6;

    localparam logic [5:0] DIV_STEPS_TRI = 6'd14;
    localparam logic [5:0] DIV_STEPS_VTX = 6'd26;
    localparam logic [5:0] XP_LAST       = 6'd11;
    localparam logic [5:0] SQ_LAST       = 6'd5;
    localparam logic [5:0] SQRT_LAST     = 6'd31;
    localparam logic [5:0] VRD_LAST      = 6'd3;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DEC, S_VRD, S_EDGE, S_XP, S_MAG, S_NCHK, S_SQ, S_SQRT,
        S_DINIT, S_DIV, S_DSTORE, S_FWR, S_ACHK, S_AWR, S_VCHK, S_RES
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLR, OP_CAPTURE, OP_VWR, OP_VRD, OP_EDGE, OP_MUL, OP_XACC,
        OP_MAG, OP_NZERO, OP_SHL, OP_SHR, OP_SQACC, OP_SQRT, OP_DIV_INIT,
        OP_DIV_STEP, OP_DIV_STORE, OP_FWR, OP_FRD, OP_ARD, OP_AWR,
        OP_RES_ZERO, OP_RES_NORM, OP_RES_FACE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] idx;
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       slot_bad;
        logic       corner_bad;
        logic       dup_b;
        logic       dup_c;
        logic       mx_zero;
        logic       norm_lo;
        logic       norm_hi;
        logic       cnt_zero;
        logic       clr_last;
        logic       out_free;
    } sts_t;

endpackage

// File: hw/rtl/mna_ctrl.sv
// sequencing state machine of the mesh normal accumulator
`include "mesh_normal_accumulator_defines.svh"

module mna_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mna_pkg::sts_t sts,
    output mna_pkg::cmd_t cmd
);
    import mna_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    op_t        res_op_reg, res_op_next;
    logic [1:0] res_code_reg, res_code_next;
    logic       skip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            cnt_reg      <= '0;
            comp_reg     <= '0;
            res_op_reg   <= OP_RES_ZERO;
            res_code_reg <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            comp_reg     <= comp_next;
            res_op_reg   <= res_op_next;
            res_code_reg <= res_code_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        comp_next     = comp_reg;
        res_op_next   = res_op_reg;
        res_code_next = res_code_reg;
        in_ready      = 1'b0;
        cmd.op        = OP_NOP;
        cmd.idx       = '0;
        cmd.code      = res_code_reg;
        skip          = ((comp_reg == 2'd1) && sts.dup_b) || ((comp_reg == 2'd2) && sts.dup_c);
        case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next  = S_RES;
                res_op_next = OP_RES_ZERO;
                if (sts.slot_bad)
                    res_code_next = ST_SLOT;
                else
                begin
                    res_code_next = ST_OK;
                    case (sts.mode)
                        MODE_VTX_WR: cmd.op = OP_VWR;
                        MODE_TRI:
                        begin
                            if (sts.corner_bad)
                                res_code_next = ST_CORNER;
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_VRD;
                            end
                        end
                        MODE_VNORM:
                        begin
                            cmd.op     = OP_ARD;
                            cmd.idx    = ASEL_SLOT;
                            state_next = S_VCHK;
                        end
                        default:
                        begin
                            cmd.op      = OP_FRD;
                            res_op_next = OP_RES_FACE;
                        end
                    endcase
                end
            end
            S_VRD:
            begin
                cmd.op  = OP_VRD;
                cmd.idx = cnt_reg[3:0];
                if (cnt_reg == VRD_LAST)
                    state_next = S_EDGE;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_EDGE:
            begin
                cmd.op     = OP_EDGE;
                cnt_next   = '0;
                state_next = S_XP;
            end
            S_XP:
            begin
                cmd.op  = cnt_reg[0] ? OP_XACC : OP_MUL;
                cmd.idx = cnt_reg[4:1];
                if (cnt_reg == XP_LAST)
                    state_next = S_MAG;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                res_op_next   = OP_RES_NORM;
                res_code_next = sts.mx_zero ? ST_ZERO : ST_OK;
                if (sts.mx_zero)
                begin
                    cmd.op     = OP_NZERO;
                    state_next = S_FWR;
                end
                else if (sts.norm_lo)
                    cmd.op = OP_SHL;
                else if (sts.norm_hi)
                    cmd.op = OP_SHR;
                else
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op  = cnt_reg[0] ? OP_SQACC : OP_MUL;
                cmd.idx = cnt_reg[0] ? cnt_reg[4:1] : (MUL_SQ_BASE + cnt_reg[4:1]);
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == SQRT_LAST)
                begin
                    comp_next  = '0;
                    state_next = S_DINIT;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cmd.idx    = {2'b00, comp_reg};
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (cnt_reg == ((sts.mode == MODE_TRI) ? DIV_STEPS_TRI : DIV_STEPS_VTX))
                    state_next = S_DSTORE;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_DSTORE:
            begin
                cmd.op  = OP_DIV_STORE;
                cmd.idx = {2'b00, comp_reg};
                if (comp_reg == 2'd2)
                    state_next = (sts.mode == MODE_TRI) ? S_FWR : S_RES;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DINIT;
                end
            end
            S_FWR:
            begin
                cmd.op     = OP_FWR;
                comp_next  = '0;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (skip)
                begin
                    if (comp_reg == 2'd2)
                        state_next = S_RES;
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                begin
                    cmd.op     = OP_ARD;
                    cmd.idx    = {2'b00, comp_reg};
                    state_next = S_AWR;
                end
            end
            S_AWR:
            begin
                cmd.op  = OP_AWR;
                cmd.idx = {2'b00, comp_reg};
                if (comp_reg == 2'd2)
                    state_next = S_RES;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_ACHK;
                end
            end
            S_VCHK:
            begin
                if (sts.cnt_zero)
                begin
                    res_op_next   = OP_RES_ZERO;
                    res_code_next = ST_ZERO;
                    state_next    = S_RES;
                end
                else
                begin
                    res_op_next   = OP_RES_NORM;
                    res_code_next = ST_OK;
                    comp_next     = '0;
                    state_next    = S_DINIT;
                end
            end
            S_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = res_op_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `MNA_ASSERT_NEXT(a_accept_decodes, (state_reg == S_IDLE) && in_valid, state_reg == S_DEC)
    `MNA_ASSERT_NEXT(a_result_returns, (state_reg == S_RES) && sts.out_free, state_reg == S_IDLE)
    `MNA_ASSERT_SAME(a_sq_normalized, state_reg == S_SQ, !sts.norm_lo && !sts.norm_hi)

endmodule

// File: hw/rtl/mna_dpath.sv
// memories, shared multiplier, square root and divider of the mesh normal accumulator
module mna_dpath #(
    parameter int MAX_VERTICES  = mna_pkg::MAX_VERTICES_DEF,
    parameter int MAX_TRIANGLES = mna_pkg::MAX_TRIANGLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mna_pkg::IN_DATA_W-1:0]  in_data,
    input  logic [1:0]                     in_mode,
    input  mna_pkg::cmd_t                  cmd,
    output mna_pkg::sts_t                  sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mna_pkg::OUT_DATA_W-1:0] out_data,
    output logic [1:0]                     out_status
);
    import mna_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    // item word
    logic [1:0]         mode_reg;
    logic [10:0]        slot_reg;
    logic [47:0]        pos_reg;
    logic [9:0]         corner_reg [3];

    logic [47:0]        vpos_mem [MAX_VERTICES];
    logic [47:0]        fnorm_mem [MAX_TRIANGLES];
    logic [92:0]        acc_mem [MAX_VERTICES];
    logic [47:0]        vrd_reg, frd_reg;
    logic [92:0]        ard_reg;

    logic [47:0]        p_reg [3];
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [34:0] cr_reg [3];
    logic [34:0]        mag_reg [3];
    logic [63:0]        sq_reg, res_reg, bit_reg, sq_try;
    logic [31:0]        rem_reg, dvb_reg, dvs_reg, q_reg;
    logic [32:0]        div_try;
    logic               div_ge;
    logic signed [15:0] n_reg [3];

    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]         out_status_reg;
    logic [VW-1:0]      clr_addr_reg;

    logic [VW-1:0]      vaddr, aaddr;
    logic signed [26:0] ard_sum [3];
    logic [26:0]        ard_abs [3];
    logic [11:0]        ard_cnt;
    logic [1:0]         ci;

    assign ci = cmd.idx[1:0];

    always_comb
    begin
        vaddr = VW'(corner_reg[0]);
        aaddr = VW'(slot_reg);
        case (cmd.idx)
            4'd1: vaddr = VW'(corner_reg[1]);
            4'd2: vaddr = VW'(corner_reg[2]);
            default: vaddr = VW'(corner_reg[0]);
        endcase
        if (cmd.idx != ASEL_SLOT)
            aaddr = vaddr;
        for (int i = 0; i < 3; i++)
        begin
            ard_sum[i] = $signed(ard_reg[27*i +: 27]);
            ard_abs[i] = ard_sum[i][26] ? 27'(-ard_sum[i]) : 27'(ard_sum[i]);
        end
        ard_cnt = ard_reg[92:81];
    end

    // shared multiplier operand selection
    always_comb
    begin
        case (cmd.idx)
            4'd0: begin mul_a = 33'(e1_reg[1]); mul_b = 33'(e2_reg[2]); end
            4'd1: begin mul_a = 33'(e1_reg[2]); mul_b = 33'(e2_reg[1]); end
            4'd2: begin mul_a = 33'(e1_reg[2]); mul_b = 33'(e2_reg[0]); end
            4'd3: begin mul_a = 33'(e1_reg[0]); mul_b = 33'(e2_reg[2]); end
            4'd4: begin mul_a = 33'(e1_reg[0]); mul_b = 33'(e2_reg[1]); end
            4'd5: begin mul_a = 33'(e1_reg[1]); mul_b = 33'(e2_reg[0]); end
            4'd6:
            begin
                mul_a = $signed({3'b000, mag_reg[0][29:0]});
                mul_b = mul_a;
            end
            4'd7:
            begin
                mul_a = $signed({3'b000, mag_reg[1][29:0]});
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = $signed({3'b000, mag_reg[2][29:0]});
                mul_b = mul_a;
            end
        endcase
    end

    assign sq_try  = res_reg + bit_reg;
    assign div_try = {rem_reg, dvb_reg[31]};
    assign div_ge  = div_try >= {1'b0, dvs_reg};

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_VWR)
            vpos_mem[VW'(slot_reg)] <= pos_reg;
        if (cmd.op == OP_VRD && cmd.idx != ASEL_SLOT)
            vrd_reg <= vpos_mem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FWR)
            fnorm_mem[TW'(slot_reg)] <= {n_reg[2], n_reg[1], n_reg[0]};
        if (cmd.op == OP_FRD)
            frd_reg <= fnorm_mem[TW'(slot_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLR)
            acc_mem[clr_addr_reg] <= '0;
        else if (cmd.op == OP_AWR && ard_cnt < COUNT_MAX)
            acc_mem[aaddr] <= {ard_cnt + 12'd1,
                               ard_sum[2] + 27'(n_reg[2]),
                               ard_sum[1] + 27'(n_reg[1]),
                               ard_sum[0] + 27'(n_reg[0])};
        if (cmd.op == OP_ARD)
            ard_reg <= acc_mem[aaddr];
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                mode_reg      <= in_mode;
                slot_reg      <= in_data[10:0];
                pos_reg       <= in_data[58:11];
                corner_reg[0] <= in_data[68:59];
                corner_reg[1] <= in_data[78:69];
                corner_reg[2] <= in_data[88:79];
            end
            OP_VRD:
                if (cmd.idx != 4'd0)
                    p_reg[2'(cmd.idx - 4'd1)] <= vrd_reg;
            OP_EDGE:
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= 17'($signed(p_reg[1][16*i +: 16]))
                               - 17'($signed(p_reg[0][16*i +: 16]));
                    e2_reg[i] <= 17'($signed(p_reg[2][16*i +: 16]))
                               - 17'($signed(p_reg[0][16*i +: 16]));
                end
            OP_MUL: prod_reg <= mul_a * mul_b;
            OP_XACC:
                if (cmd.idx[0])
                    cr_reg[cmd.idx[2:1]] <= cr_reg[cmd.idx[2:1]] - prod_reg[34:0];
                else
                    cr_reg[cmd.idx[2:1]] <= prod_reg[34:0];
            OP_MAG:
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= cr_reg[i][34] ? 35'(-cr_reg[i]) : 35'(cr_reg[i]);
            OP_NZERO:
                for (int i = 0; i < 3; i++)
                    n_reg[i] <= '0;
            OP_SHL:
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= {mag_reg[i][33:0], 1'b0};
            OP_SHR:
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= {1'b0, mag_reg[i][34:1]};
            OP_SQACC:
                if (cmd.idx == 4'd0)
                begin
                    sq_reg  <= 64'(prod_reg[59:0]);
                    res_reg <= '0;
                    bit_reg <= 64'h4000_0000_0000_0000;
                end
                else
                    sq_reg <= sq_reg + 64'(prod_reg[59:0]);
            OP_SQRT:
            begin
                if (sq_reg >= sq_try)
                begin
                    sq_reg  <= sq_reg - sq_try;
                    res_reg <= {1'b0, res_reg[63:1]} + bit_reg;
                end
                else
                    res_reg <= {1'b0, res_reg[63:1]};
                bit_reg <= {2'b00, bit_reg[63:2]};
            end
            OP_DIV_INIT:
            begin
                q_reg <= '0;
                if (mode_reg == MODE_TRI)
                begin
                    rem_reg <= 32'(mag_reg[ci][29:1]);
                    dvb_reg <= {mag_reg[ci][0], 31'b0};
                    dvs_reg <= res_reg[31:0];
                end
                else
                begin
                    rem_reg <= '0;
                    dvb_reg <= {ard_abs[ci], 5'b0};
                    dvs_reg <= 32'(ard_cnt);
                end
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? 32'(div_try - {1'b0, dvs_reg}) : div_try[31:0];
                dvb_reg <= {dvb_reg[30:0], 1'b0};
                q_reg   <= {q_reg[30:0], div_ge};
            end
            OP_DIV_STORE:
                if ((mode_reg == MODE_TRI) ? cr_reg[ci][34] : ard_sum[ci][26])
                    n_reg[ci] <= $signed(-q_reg[15:0]);
                else
                    n_reg[ci] <= $signed(q_reg[15:0]);
            OP_RES_ZERO:
            begin
                out_data_reg   <= '0;
                out_status_reg <= cmd.code;
            end
            OP_RES_NORM:
            begin
                out_data_reg   <= {4'b0, (mode_reg == MODE_VNORM) ? ard_cnt : 12'd0,
                                   n_reg[2], n_reg[1], n_reg[0]};
                out_status_reg <= cmd.code;
            end
            OP_RES_FACE:
            begin
                out_data_reg   <= {16'b0, frd_reg};
                out_status_reg <= (frd_reg == '0) ? ST_ZERO : ST_OK;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (cmd.op == OP_RES_ZERO || cmd.op == OP_RES_NORM || cmd.op == OP_RES_FACE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.op == OP_CLR)
                clr_addr_reg <= clr_addr_reg + VW'(1);
        end
    end

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.slot_bad   = (mode_reg == MODE_VTX_WR || mode_reg == MODE_VNORM)
                       ? (32'(slot_reg) >= 32'(MAX_VERTICES))
                       : (32'(slot_reg) >= 32'(MAX_TRIANGLES));
        sts.corner_bad = (32'(corner_reg[0]) >= 32'(MAX_VERTICES))
                       || (32'(corner_reg[1]) >= 32'(MAX_VERTICES))
                       || (32'(corner_reg[2]) >= 32'(MAX_VERTICES));
        sts.dup_b      = corner_reg[1] == corner_reg[0];
        sts.dup_c      = (corner_reg[2] == corner_reg[0]) || (corner_reg[2] == corner_reg[1]);
        sts.mx_zero    = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        sts.norm_hi    = (|mag_reg[0][34:30]) || (|mag_reg[1][34:30]) || (|mag_reg[2][34:30]);
        sts.norm_lo    = !(|mag_reg[0][34:29]) && !(|mag_reg[1][34:29])
                       && !(|mag_reg[2][34:29]);
        sts.cnt_zero   = ard_cnt == '0;
        sts.clr_last   = clr_addr_reg == VW'(MAX_VERTICES - 1);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

// File: hw/rtl/mesh_normal_accumulator.sv
// mesh normal accumulator top level: vertex store, face normals, vertex normal averaging
// a triangle load runs the cross product, the normalize shift, the square root and
// three 15-step divides; one word is in flight at a time, set by the shared
// multiplier, the bit-serial square root and the restoring divider
// reset: a clearing pass zeroes the sums and use counts, no word taken
module mesh_normal_accumulator #(
    parameter int MAX_VERTICES  = mna_pkg::MAX_VERTICES_DEF,
    parameter int MAX_TRIANGLES = mna_pkg::MAX_TRIANGLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, zero fill
    input  logic [mna_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [1:0]                     s_tuser,
    // master side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // normal_x, normal_y, normal_z, users, zero fill
    output logic [mna_pkg::OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]                     m_tuser
);
    import mna_pkg::*;

    cmd_t cmd;   // controller to datapath
    sts_t sts;   // datapath flags back to controller

    // state machine: clearing pass, decode, and the step sequence of each mode
    mna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: the three memories, multiplier, square root, divider and output register
    mna_dpath #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (s_tdata),
        .in_mode    (s_tuser),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

endmodule
